FILE: rtl/core/point_ellipse_distance_macros.svh
// ----------------------------------------------------------------------------
// point_ellipse_distance assertion macros
// Concurrent check helpers; compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef POINT_ELLIPSE_DISTANCE_MACROS_SVH
`define POINT_ELLIPSE_DISTANCE_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define PED_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("point_ellipse_distance: same-cycle check failed");
// next-cycle implication
`define PED_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("point_ellipse_distance: next-cycle check failed");
`else
`define PED_ASSERT_IMP(label, ante, cons)
`define PED_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: rtl/core/ped_pkg.sv
// ----------------------------------------------------------------------------
// ped_pkg
// Shared constants and types of the point-to-ellipse distance block.
// ----------------------------------------------------------------------------
package ped_pkg;

	// bisection iteration cap
	localparam int ITER_LIMIT = 64;
	localparam int ITER_W     = $clog2(ITER_LIMIT + 1);

	// shared unit geometry
	localparam int WORD_W     = 64;
	localparam int MUL_W      = 33;
	localparam int STEPS      = 32;
	localparam int STEP_W     = $clog2(STEPS);

	// fixed-point constants
	localparam logic [WORD_W-1:0] ONE32     = 64'h0000_0001_0000_0000;
	localparam logic [WORD_W-1:0] HALF64    = 64'h8000_0000_0000_0000;
	localparam logic [WORD_W-1:0] ROOT_BIT0 = 64'h4000_0000_0000_0000;
	localparam logic [WORD_W-1:0] LIM64     = 64'h0000_0000_FFFF_FFFF;
	localparam logic [31:0]       OUT_MAX   = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		ALU_MUL,
		ALU_DIV,
		ALU_SQRT
	} alu_op_t;

	typedef struct packed {
		logic              go;
		alu_op_t           op;
		logic [WORD_W-1:0] x;
		logic [WORD_W-1:0] y;
	} alu_req_t;

	typedef struct packed {
		logic              done;
		logic [WORD_W-1:0] result;
	} alu_rsp_t;

endpackage

FILE: rtl/core/ped_alu.sv
// ----------------------------------------------------------------------------
// ped_alu
// Shared arithmetic unit: registered 33x33 multiply, bit-serial Q0.32
// fraction divide and bit-serial integer square root.
// ----------------------------------------------------------------------------
module ped_alu (
	input  logic              clk,
	input  logic              arst_n,
	input  ped_pkg::alu_req_t req,
	output ped_pkg::alu_rsp_t rsp
);
	import ped_pkg::*;

	alu_op_t             op_q;
	logic                busy_q;
	logic                done_q;
	logic [STEP_W-1:0]   cnt_q;
	logic [WORD_W-1:0]   rem_q;
	logic [WORD_W-1:0]   den_q;
	logic [WORD_W-1:0]   acc_q;
	logic [WORD_W-1:0]   res_q;

	logic [2*MUL_W-1:0]  prod;
	logic [WORD_W:0]     rem2;
	logic                div_ge;
	logic [WORD_W-1:0]   trial;
	logic                sq_ge;
	logic [WORD_W-1:0]   rem_nx;
	logic [WORD_W-1:0]   den_nx;
	logic [WORD_W-1:0]   acc_nx;

	// multiplier
	assign prod = (2*MUL_W)'(req.x[MUL_W-1:0]) * (2*MUL_W)'(req.y[MUL_W-1:0]);

	// one divide or root step
	always_comb begin
		rem2   = {rem_q, 1'b0};
		div_ge = rem2 >= {1'b0, den_q};
		trial  = acc_q + den_q;
		sq_ge  = rem_q >= trial;
		if (op_q == ALU_DIV) begin
			rem_nx = div_ge ? WORD_W'(rem2 - {1'b0, den_q}) : rem2[WORD_W-1:0];
			den_nx = den_q;
			acc_nx = {acc_q[WORD_W-2:0], div_ge};
		end else begin
			rem_nx = sq_ge ? rem_q - trial : rem_q;
			den_nx = den_q >> 2;
			acc_nx = sq_ge ? (acc_q >> 1) + den_q : acc_q >> 1;
		end
	end

	// operation control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q   <= ALU_MUL;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
			acc_q  <= '0;
			res_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				op_q <= req.op;
				unique case (req.op)
					ALU_MUL: begin
						res_q  <= prod[WORD_W-1:0];
						done_q <= 1'b1;
					end
					ALU_DIV: begin
						if (req.y == '0 || req.x >= req.y) begin
							res_q  <= ONE32;
							done_q <= 1'b1;
						end else begin
							rem_q  <= req.x;
							den_q  <= req.y;
							acc_q  <= '0;
							cnt_q  <= '0;
							busy_q <= 1'b1;
						end
					end
					ALU_SQRT: begin
						rem_q  <= req.x;
						den_q  <= ROOT_BIT0;
						acc_q  <= '0;
						cnt_q  <= '0;
						busy_q <= 1'b1;
					end
					default: ;
				endcase
			end else if (busy_q) begin
				rem_q <= rem_nx;
				den_q <= den_nx;
				acc_q <= acc_nx;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == STEP_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					res_q  <= acc_nx;
				end
			end
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = res_q;

endmodule

FILE: rtl/core/point_ellipse_distance.sv
// ----------------------------------------------------------------------------
// point_ellipse_distance
// Nearest point on an axis-aligned ellipse and the distance to it, by
// bisection on the shifted Lagrange multiplier, unsigned Q16.16.
// ----------------------------------------------------------------------------
//  channel  | handshake            | fields
//  ---------+----------------------+-------------------------------------------
//  item in  | start & !busy        | semi_axis_major semi_axis_minor
//           |                      | query_first query_second
//  item out | done (1-cycle pulse) | nearest_first nearest_second distance
//           |                      | bad_axes
//
//  bad axes return to idle from the axis check; other items go on to normalization
//  normalization shifts one bit per cycle
//  each divide, root and multiply runs on the shared unit
//  up to 64 bisection steps per item
//  no clearing pass after reset; results cannot be stalled
// ----------------------------------------------------------------------------
`include "point_ellipse_distance_macros.svh"

module point_ellipse_distance (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] semi_axis_major,
	input  logic [31:0] semi_axis_minor,
	input  logic [31:0] query_first,
	input  logic [31:0] query_second,
	output logic        done,
	output logic [31:0] nearest_first,
	output logic [31:0] nearest_second,
	output logic [31:0] distance,
	output logic        bad_axes
);
	import ped_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE, S_CHECK, S_NORM,
		S_MUL_AU, S_MUL_BV, S_MUL_BB, S_MUL_AA, S_BRANCH,
		S_FS_D0, S_FS_TEST, S_FS_DIVP, S_FS_MULP, S_FS_DIVQ, S_FS_MULQ,
		S_FS_SUM, S_FS_RET,
		S_BIS_MID, S_BIS_ADD, S_BIS_CHK,
		S_RL_DIV, S_RL_SQ, S_RL_SQRT, S_RL_MUL1, S_RL_MUL2,
		S_FIN_DIV0, S_FIN_MUL0, S_FIN_DIV1, S_FIN_MUL1,
		S_DIST, S_DSQ0, S_DSQ1, S_DSQRT,
		S_INT_DIV, S_INT_X0, S_INT_SQ, S_INT_SQRT, S_INT_X1,
		S_UNS
	} state_t;

	state_t             state_q;
	logic               issued_q;
	logic [31:0]        a_q, b_q, u_q, v_q, m_q;
	logic signed [5:0]  sh_q;
	logic [WORD_W-1:0]  au_q, bv_q, bb_q, c_q;
	logic [WORD_W-1:0]  lo_q, hi_q, mid_q, t0_q, t1_q;
	logic [WORD_W-1:0]  x0_q, x1_q, d_q;
	logic               loop_q, pos_q, zero_q;
	logic [ITER_W-1:0]  it_q;
	logic [1:0]         uidx_q;
	logic               done_q, bad_q;
	logic [31:0]        nf_q, ns_q, dist_q;

	alu_req_t           alu_req;
	alu_rsp_t           alu_rsp;
	logic               op_state;
	logic               cap;
	logic [31:0]        max_au, max3;
	logic               rl_gt;
	logic [WORD_W-1:0]  rl_max, rl_min;
	logic [WORD_W-1:0]  fs_sum;

	function automatic logic [31:0] absdiff32(input logic [31:0] p, input logic [31:0] q);
		return (p > q) ? p - q : q - p;
	endfunction

	function automatic logic [WORD_W-1:0] absdiff64(input logic [WORD_W-1:0] p,
	                                                input logic [WORD_W-1:0] q);
		return (p > q) ? p - q : q - p;
	endfunction

	// scale a result back by the normalization shift, round half up, saturate
	function automatic logic [31:0] unscale(input logic [WORD_W-1:0] r,
	                                        input logic signed [5:0] sh);
		logic [WORD_W-1:0] t;
		logic [WORD_W-1:0] rnd;
		logic [4:0]        amt;
		amt = sh[4:0];
		rnd = '0;
		t   = r;
		if (sh > 6'sd0) begin
			rnd = WORD_W'(1) << (amt - 5'd1);
			t   = (r + rnd) >> amt;
		end else if (sh < 6'sd0) begin
			// normalization shifts right by at most one bit
			t = (r > (LIM64 >> 1)) ? LIM64 : (r << 1);
		end
		return (t > LIM64) ? OUT_MAX : t[31:0];
	endfunction

	// largest of the raw major axis and query coordinates
	assign max_au = (a_q > u_q) ? a_q : u_q;
	assign max3   = (max_au > v_q) ? max_au : v_q;

	// ordering for the robust length
	assign rl_gt  = au_q > bv_q;
	assign rl_max = rl_gt ? au_q : bv_q;
	assign rl_min = rl_gt ? bv_q : au_q;

	assign fs_sum = (t1_q >> 1) + (t0_q >> 1);

	// request to the shared unit
	always_comb begin
		op_state = 1'b0;
		alu_req.op = ALU_MUL;
		alu_req.x  = '0;
		alu_req.y  = '0;
		unique case (state_q)
			S_MUL_AU: begin
				op_state = 1'b1; alu_req.x = {32'd0, a_q}; alu_req.y = {32'd0, u_q};
			end
			S_MUL_BV: begin
				op_state = 1'b1; alu_req.x = {32'd0, b_q}; alu_req.y = {32'd0, v_q};
			end
			S_MUL_BB: begin
				op_state = 1'b1; alu_req.x = {32'd0, b_q}; alu_req.y = {32'd0, b_q};
			end
			S_MUL_AA: begin
				op_state = 1'b1; alu_req.x = {32'd0, a_q}; alu_req.y = {32'd0, a_q};
			end
			S_FS_DIVP: begin
				op_state = 1'b1; alu_req.op = ALU_DIV; alu_req.x = au_q; alu_req.y = t0_q;
			end
			S_FS_MULP: begin
				op_state = 1'b1; alu_req.x = t1_q; alu_req.y = t1_q;
			end
			S_FS_DIVQ: begin
				op_state = 1'b1; alu_req.op = ALU_DIV; alu_req.x = bv_q; alu_req.y = mid_q;
			end
			S_FS_MULQ: begin
				op_state = 1'b1; alu_req.x = t0_q; alu_req.y = t0_q;
			end
			S_RL_DIV: begin
				op_state = 1'b1; alu_req.op = ALU_DIV; alu_req.x = rl_min; alu_req.y = rl_max;
			end
			S_RL_SQ: begin
				op_state = 1'b1; alu_req.x = t0_q; alu_req.y = t0_q;
			end
			S_RL_SQRT: begin
				op_state = 1'b1; alu_req.op = ALU_SQRT; alu_req.x = (ONE32 + t0_q) << 30;
			end
			S_RL_MUL1: begin
				op_state = 1'b1; alu_req.x = t1_q >> 31; alu_req.y = t0_q;
			end
			S_RL_MUL2: begin
				op_state = 1'b1; alu_req.x = WORD_W'(t1_q[30:0]); alu_req.y = t0_q;
			end
			S_FIN_DIV0: begin
				op_state = 1'b1; alu_req.op = ALU_DIV; alu_req.x = au_q; alu_req.y = mid_q + c_q;
			end
			S_FIN_MUL0: begin
				op_state = 1'b1; alu_req.x = {32'd0, a_q}; alu_req.y = t0_q;
			end
			S_FIN_DIV1: begin
				op_state = 1'b1; alu_req.op = ALU_DIV; alu_req.x = bv_q; alu_req.y = mid_q;
			end
			S_FIN_MUL1: begin
				op_state = 1'b1; alu_req.x = {32'd0, b_q}; alu_req.y = t0_q;
			end
			S_DSQ0: begin
				op_state = 1'b1; alu_req.x = t0_q; alu_req.y = t0_q;
			end
			S_DSQ1: begin
				op_state = 1'b1; alu_req.x = t1_q; alu_req.y = t1_q;
			end
			S_DSQRT: begin
				op_state = 1'b1; alu_req.op = ALU_SQRT; alu_req.x = t0_q + t1_q;
			end
			S_INT_DIV: begin
				op_state = 1'b1; alu_req.op = ALU_DIV; alu_req.x = au_q; alu_req.y = c_q;
			end
			S_INT_X0: begin
				op_state = 1'b1; alu_req.x = {32'd0, a_q}; alu_req.y = t0_q;
			end
			S_INT_SQ: begin
				op_state = 1'b1; alu_req.x = t0_q; alu_req.y = t0_q;
			end
			S_INT_SQRT: begin
				op_state = 1'b1; alu_req.op = ALU_SQRT; alu_req.x = t1_q << 30;
			end
			S_INT_X1: begin
				op_state = 1'b1; alu_req.x = {32'd0, b_q}; alu_req.y = t1_q;
			end
			default: ;
		endcase
		alu_req.go = op_state && !issued_q;
	end

	assign cap = op_state && issued_q && alu_rsp.done;

	ped_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.rsp    (alu_rsp)
	);

	// sequencer, datapath registers and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			issued_q <= 1'b0;
			a_q <= '0; b_q <= '0; u_q <= '0; v_q <= '0; m_q <= '0;
			sh_q <= '0;
			au_q <= '0; bv_q <= '0; bb_q <= '0; c_q <= '0;
			lo_q <= '0; hi_q <= '0; mid_q <= '0; t0_q <= '0; t1_q <= '0;
			x0_q <= '0; x1_q <= '0; d_q <= '0;
			loop_q <= 1'b0; pos_q <= 1'b0; zero_q <= 1'b0;
			it_q <= '0; uidx_q <= '0;
			done_q <= 1'b0; bad_q <= 1'b0;
			nf_q <= '0; ns_q <= '0; dist_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (alu_req.go) begin
				issued_q <= 1'b1;
			end else if (cap) begin
				issued_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						a_q <= semi_axis_major;
						b_q <= semi_axis_minor;
						u_q <= query_first;
						v_q <= query_second;
						state_q <= S_CHECK;
					end
				end
				// axis check, then find the largest value
				S_CHECK: begin
					uidx_q <= '0;
					if (b_q == '0 || b_q > a_q) begin
						nf_q <= '0; ns_q <= '0; dist_q <= '0;
						bad_q <= 1'b1;
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						m_q <= max3;
						sh_q <= '0;
						state_q <= S_NORM;
					end
				end
				// one bit of normalization per cycle
				S_NORM: begin
					if (m_q[31]) begin
						a_q <= (a_q[31:1] == '0) ? 32'd1 : {1'b0, a_q[31:1]};
						b_q <= (b_q[31:1] == '0) ? 32'd1 : {1'b0, b_q[31:1]};
						u_q <= {1'b0, u_q[31:1]};
						v_q <= {1'b0, v_q[31:1]};
						sh_q <= -6'sd1;
						state_q <= S_MUL_AU;
					end else if (!m_q[30]) begin
						a_q <= a_q << 1; b_q <= b_q << 1;
						u_q <= u_q << 1; v_q <= v_q << 1;
						m_q <= m_q << 1;
						sh_q <= sh_q + 6'sd1;
					end else begin
						state_q <= S_MUL_AU;
					end
				end
				S_MUL_AU: if (cap) begin au_q <= alu_rsp.result; state_q <= S_MUL_BV; end
				S_MUL_BV: if (cap) begin bv_q <= alu_rsp.result; state_q <= S_MUL_BB; end
				S_MUL_BB: if (cap) begin bb_q <= alu_rsp.result; state_q <= S_MUL_AA; end
				S_MUL_AA: if (cap) begin
					c_q <= alu_rsp.result - bb_q;
					state_q <= S_BRANCH;
				end
				// general case or one of the on-axis cases
				S_BRANCH: begin
					it_q <= '0;
					loop_q <= 1'b0;
					if (u_q != '0 && v_q != '0) begin
						mid_q <= bb_q;
						state_q <= S_FS_D0;
					end else if (v_q != '0) begin
						x0_q <= '0;
						x1_q <= {32'd0, b_q};
						d_q  <= {32'd0, absdiff32(v_q, b_q)};
						state_q <= S_UNS;
					end else if (au_q < c_q) begin
						state_q <= S_INT_DIV;
					end else begin
						x0_q <= {32'd0, a_q};
						x1_q <= '0;
						d_q  <= {32'd0, absdiff32(u_q, a_q)};
						state_q <= S_UNS;
					end
				end
				// sign of the secular function at mid
				S_FS_D0: begin
					t0_q <= mid_q + c_q;
					state_q <= S_FS_TEST;
				end
				S_FS_TEST: begin
					if (au_q >= t0_q || bv_q >= mid_q) begin
						pos_q <= 1'b1;
						zero_q <= 1'b0;
						state_q <= S_FS_RET;
					end else begin
						state_q <= S_FS_DIVP;
					end
				end
				S_FS_DIVP: if (cap) begin t1_q <= alu_rsp.result; state_q <= S_FS_MULP; end
				S_FS_MULP: if (cap) begin t1_q <= alu_rsp.result; state_q <= S_FS_DIVQ; end
				S_FS_DIVQ: if (cap) begin t0_q <= alu_rsp.result; state_q <= S_FS_MULQ; end
				S_FS_MULQ: if (cap) begin t0_q <= alu_rsp.result; state_q <= S_FS_SUM; end
				S_FS_SUM: begin
					pos_q <= fs_sum > HALF64;
					zero_q <= fs_sum == HALF64;
					state_q <= S_FS_RET;
				end
				S_FS_RET: begin
					if (!loop_q) begin
						if (zero_q) begin
							// query already on the ellipse
							x0_q <= {32'd0, u_q};
							x1_q <= {32'd0, v_q};
							d_q  <= '0;
							state_q <= S_UNS;
						end else begin
							lo_q <= bv_q;
							if (pos_q) begin
								state_q <= S_RL_DIV;
							end else begin
								hi_q <= bb_q;
								state_q <= S_BIS_MID;
							end
						end
					end else if (zero_q) begin
						state_q <= S_FIN_DIV0;
					end else begin
						if (pos_q) lo_q <= mid_q;
						else hi_q <= mid_q;
						it_q <= it_q + 1'b1;
						state_q <= S_BIS_MID;
					end
				end
				// bisection midpoint
				S_BIS_MID: begin
					if (it_q == ITER_W'(ITER_LIMIT)) begin
						state_q <= S_FIN_DIV0;
					end else begin
						t0_q <= hi_q - lo_q;
						state_q <= S_BIS_ADD;
					end
				end
				S_BIS_ADD: begin
					mid_q <= lo_q + (t0_q >> 1);
					state_q <= S_BIS_CHK;
				end
				S_BIS_CHK: begin
					if (mid_q == lo_q || mid_q == hi_q) begin
						state_q <= S_FIN_DIV0;
					end else begin
						loop_q <= 1'b1;
						state_q <= S_FS_D0;
					end
				end
				// upper bracket from the robust length of (a*u, b*v)
				S_RL_DIV: if (cap) begin
					t0_q <= alu_rsp.result;
					t1_q <= rl_max;
					state_q <= S_RL_SQ;
				end
				S_RL_SQ: if (cap) begin
					t0_q <= t0_q[32] ? ONE32 : alu_rsp.result >> 32;
					state_q <= S_RL_SQRT;
				end
				S_RL_SQRT: if (cap) begin t0_q <= alu_rsp.result; state_q <= S_RL_MUL1; end
				S_RL_MUL1: if (cap) begin hi_q <= alu_rsp.result; state_q <= S_RL_MUL2; end
				S_RL_MUL2: if (cap) begin
					hi_q <= hi_q + (alu_rsp.result >> 31);
					state_q <= S_BIS_MID;
				end
				// nearest point from the final multiplier
				S_FIN_DIV0: if (cap) begin t0_q <= alu_rsp.result; state_q <= S_FIN_MUL0; end
				S_FIN_MUL0: if (cap) begin x0_q <= alu_rsp.result >> 32; state_q <= S_FIN_DIV1; end
				S_FIN_DIV1: if (cap) begin t0_q <= alu_rsp.result; state_q <= S_FIN_MUL1; end
				S_FIN_MUL1: if (cap) begin x1_q <= alu_rsp.result >> 32; state_q <= S_DIST; end
				// euclidean distance
				S_DIST: begin
					t0_q <= absdiff64(x0_q, {32'd0, u_q});
					t1_q <= absdiff64(x1_q, {32'd0, v_q});
					state_q <= S_DSQ0;
				end
				S_DSQ0:  if (cap) begin t0_q <= alu_rsp.result; state_q <= S_DSQ1; end
				S_DSQ1:  if (cap) begin t1_q <= alu_rsp.result; state_q <= S_DSQRT; end
				S_DSQRT: if (cap) begin d_q <= alu_rsp.result; state_q <= S_UNS; end
				// second coordinate zero, inside the evolute: closed form
				S_INT_DIV: if (cap) begin t0_q <= alu_rsp.result; state_q <= S_INT_X0; end
				S_INT_X0:  if (cap) begin x0_q <= alu_rsp.result >> 32; state_q <= S_INT_SQ; end
				S_INT_SQ:  if (cap) begin
					t1_q <= ONE32 - (alu_rsp.result >> 32);
					state_q <= S_INT_SQRT;
				end
				S_INT_SQRT: if (cap) begin t1_q <= alu_rsp.result; state_q <= S_INT_X1; end
				// v is zero here, so the distance pass sees dy = x1
				S_INT_X1: if (cap) begin x1_q <= alu_rsp.result >> 31; state_q <= S_DIST; end
				// scale back one result per cycle
				S_UNS: begin
					uidx_q <= uidx_q + 2'd1;
					if (uidx_q == 2'd0) begin
						nf_q <= unscale(x0_q, sh_q);
					end else if (uidx_q == 2'd1) begin
						ns_q <= unscale(x1_q, sh_q);
					end else begin
						dist_q <= unscale(d_q, sh_q);
						bad_q <= 1'b0;
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy           = state_q != S_IDLE;
	assign done           = done_q;
	assign nearest_first  = nf_q;
	assign nearest_second = ns_q;
	assign distance       = dist_q;
	assign bad_axes       = bad_q;

	// checks
	`PED_ASSERT_IMP(a_done_idle, done, !busy)
	`PED_ASSERT_NEXT(a_start_busy, start && !busy, busy)
	`PED_ASSERT_NEXT(a_done_pulse, done, !done)
	`PED_ASSERT_IMP(a_bad_zero, done && bad_axes, (nearest_first | nearest_second | distance) == 32'd0)

endmodule

FILE: tb/tb_point_ellipse_distance.sv
// ----------------------------------------------------------------------------
// tb_point_ellipse_distance
// Drives ellipse/query items through the command handshake, predicts the
// nearest point and distance with a fixed-point bisection model, and checks
// each done pulse against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_point_ellipse_distance;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITER_CAP   = 64;
	localparam int NORM_W     = 31;
	localparam longint unsigned UNIT = 64'h1_0000_0000;
	localparam longint unsigned MASK32 = 64'hFFFF_FFFF;
	localparam longint CYCLE_LIMIT = 64'd30_000_000;

	typedef struct {
		logic [31:0] nearest_first;
		logic [31:0] nearest_second;
		logic [31:0] distance;
		logic        bad_axes;
	} ellipse_answer_t;

	// integer floor square root of a 64-bit value
	function automatic longint unsigned floor_root(longint unsigned x);
		longint unsigned r, bitv;
		r = 0;
		bitv = 64'd1 << 62;
		while (bitv > x) bitv >>= 2;
		while (bitv != 0) begin
			if (x >= r + bitv) begin
				x -= r + bitv;
				r = (r >> 1) + bitv;
			end else
				r >>= 1;
			bitv >>= 2;
		end
		return r;
	endfunction

	// q0.32 ratio, capped at one
	function automatic longint unsigned ratio_q32(longint unsigned n, longint unsigned d);
		longint unsigned q;
		q = 0;
		if (d == 0 || n >= d)
			return UNIT;
		for (int i = 0; i < 32; i++) begin
			q <<= 1;
			if (n >= d - n) begin
				n = n - (d - n);
				q |= 1;
			end else
				n = n + n;
		end
		return q;
	endfunction

	function automatic longint unsigned gap(longint unsigned x, longint unsigned y);
		return x > y ? x - y : y - x;
	endfunction

	// overflow-safe vector length
	function automatic longint unsigned hypot_len(longint unsigned x, longint unsigned y);
		longint unsigned m, n, r, r2, f;
		m = x > y ? x : y;
		n = x > y ? y : x;
		r = ratio_q32(n, m);
		r2 = (r >= UNIT) ? UNIT : ((r * r) >> 32);
		f = floor_root((UNIT + r2) << 30);
		return (m >> 31) * f + (((m & ((64'd1 << 31) - 1)) * f) >> 31);
	endfunction

	// sign of the secular function at multiplier w
	function automatic int secular_sign(longint unsigned a, longint unsigned b,
			longint unsigned u, longint unsigned v, longint unsigned w);
		longint unsigned n0, d0, n1, p, q, s;
		n0 = a * u;
		d0 = w + (a * a - b * b);
		n1 = b * v;
		if (n0 >= d0 || n1 >= w)
			return 1;
		p = ratio_q32(n0, d0);
		q = ratio_q32(n1, w);
		s = ((p * p) >> 1) + ((q * q) >> 1);
		return s > (64'd1 << 63) ? 1 : (s < (64'd1 << 63) ? -1 : 0);
	endfunction

	function automatic longint unsigned scale_back(longint unsigned r, int sh);
		if (sh > 0)
			r = (r + (64'd1 << (sh - 1))) >> sh;
		else if (sh < 0)
			r = (r > (MASK32 >> (-sh))) ? MASK32 : (r << (-sh));
		return r > MASK32 ? MASK32 : r;
	endfunction

	function automatic ellipse_answer_t predict_nearest(logic [31:0] maj, logic [31:0] mnr,
			logic [31:0] qf, logic [31:0] qs);
		ellipse_answer_t res;
		longint unsigned a, b, u, v, m, x0, x1, d, lo, hi, mid, numer, denom, xde, om;
		int n, sh, s, g;
		a = 64'(maj); b = 64'(mnr); u = 64'(qf); v = 64'(qs);
		res = '{0, 0, 0, 1'b1};
		if (b == 0 || b > a)
			return res;
		res.bad_axes = 1'b0;
		m = a;
		if (u > m) m = u;
		if (v > m) m = v;
		n = 0;
		while (n < 64 && (m >> n) != 0) n++;
		sh = NORM_W - n;
		if (sh >= 0) begin
			a <<= sh; b <<= sh; u <<= sh; v <<= sh;
		end else begin
			a >>= -sh; b >>= -sh; u >>= -sh; v >>= -sh;
			if (a == 0) a = 1;
			if (b == 0) b = 1;
		end
		if (v > 0 && u > 0) begin
			s = secular_sign(a, b, u, v, b * b);
			if (s == 0) begin
				x0 = u; x1 = v; d = 0;
			end else begin
				lo = b * v;
				hi = (s < 0) ? b * b : hypot_len(a * u, b * v);
				mid = lo;
				for (int i = 0; i < ITER_CAP; i++) begin
					mid = lo + (hi - lo) / 2;
					if (mid == lo || mid == hi) break;
					g = secular_sign(a, b, u, v, mid);
					if (g > 0) lo = mid;
					else if (g < 0) hi = mid;
					else break;
				end
				x0 = (a * ratio_q32(a * u, mid + (a * a - b * b))) >> 32;
				x1 = (b * ratio_q32(b * v, mid)) >> 32;
				d = floor_root(gap(x0, u) * gap(x0, u) + gap(x1, v) * gap(x1, v));
			end
		end else if (v > 0) begin
			x0 = 0; x1 = b; d = gap(v, b);
		end else begin
			numer = a * u;
			denom = a * a - b * b;
			if (numer < denom) begin
				xde = ratio_q32(numer, denom);
				om = UNIT - ((xde * xde) >> 32);
				x0 = (a * xde) >> 32;
				x1 = (b * floor_root(om << 30)) >> 31;
				d = floor_root(gap(x0, u) * gap(x0, u) + x1 * x1);
			end else begin
				x0 = a; x1 = 0; d = gap(u, a);
			end
		end
		res.nearest_first  = 32'(scale_back(x0, sh));
		res.nearest_second = 32'(scale_back(x1, sh));
		res.distance       = 32'(scale_back(d, sh));
		return res;
	endfunction

	// pending predictions and comparison
	class distance_scoreboard;
		ellipse_answer_t pending[$];
		int errors;

		function void note_item(logic [31:0] maj, logic [31:0] mnr,
				logic [31:0] qf, logic [31:0] qs);
			pending.insert(pending.size(), predict_nearest(maj, mnr, qf, qs));
		endfunction

		function void check_answer(ellipse_answer_t got);
			ellipse_answer_t exp_r;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result nf=%h ns=%h d=%h bad=%b", $realtime,
					got.nearest_first, got.nearest_second, got.distance, got.bad_axes);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			if (got.nearest_first !== exp_r.nearest_first) begin
				$display("%0t: nearest_first exp %h got %h", $realtime,
					exp_r.nearest_first, got.nearest_first);
				errors++;
			end
			if (got.nearest_second !== exp_r.nearest_second) begin
				$display("%0t: nearest_second exp %h got %h", $realtime,
					exp_r.nearest_second, got.nearest_second);
				errors++;
			end
			if (got.distance !== exp_r.distance) begin
				$display("%0t: distance exp %h got %h", $realtime,
					exp_r.distance, got.distance);
				errors++;
			end
			if (got.bad_axes !== exp_r.bad_axes) begin
				$display("%0t: bad_axes exp %b got %b", $realtime,
					exp_r.bad_axes, got.bad_axes);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [31:0] semi_axis_major;
	logic [31:0] semi_axis_minor;
	logic [31:0] query_first;
	logic [31:0] query_second;
	logic        done;
	logic [31:0] nearest_first;
	logic [31:0] nearest_second;
	logic [31:0] distance;
	logic        bad_axes;

	distance_scoreboard board;
	int  idle_pct;
	longint cycle_count = 0;

	point_ellipse_distance u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.semi_axis_major(semi_axis_major), .semi_axis_minor(semi_axis_minor),
		.query_first(query_first), .query_second(query_second),
		.done(done), .nearest_first(nearest_first), .nearest_second(nearest_second),
		.distance(distance), .bad_axes(bad_axes)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result capture
	always @(posedge clk) begin
		if (arst_n && done)
			board.check_answer('{nearest_first, nearest_second, distance, bad_axes});
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// present one item and hold it until accepted
	task automatic send_item(logic [31:0] maj, logic [31:0] mnr,
			logic [31:0] qf, logic [31:0] qs);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start           <= 1'b1;
		semi_axis_major <= maj;
		semi_axis_minor <= mnr;
		query_first     <= qf;
		query_second    <= qs;
		@(posedge clk);
		while (busy) @(posedge clk);
		board.note_item(maj, mnr, qf, qs);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
	endtask

	// random value with a spread of magnitudes
	function automatic logic [31:0] rand_mag();
		int w;
		w = $urandom_range(32, 1);
		return $urandom() & ((w == 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 1));
	endfunction

	task automatic send_random();
		logic [31:0] maj, mnr, qf, qs;
		int kind;
		kind = $urandom_range(99);
		maj = rand_mag();
		if (maj == 0) maj = 1;
		mnr = $urandom_range(maj, 1);
		qf = rand_mag();
		qs = rand_mag();
		if (kind < 8) begin
			mnr = (kind < 4) ? 32'd0 : $urandom();
		end else if (kind < 16) begin
			qf = 0;
		end else if (kind < 24) begin
			qs = 0;
		end else if (kind < 30) begin
			mnr = maj;
		end else if (kind < 60) begin
			// query near the ellipse scale
			qf = $urandom_range(maj);
			qs = $urandom_range(mnr);
		end
		send_item(maj, mnr, qf, qs);
	endtask

	initial begin
		board = new();
		idle_pct = 0;
		arst_n = 1'b0;
		start = 1'b0;
		semi_axis_major = '0;
		semi_axis_minor = '0;
		query_first = '0;
		query_second = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners: bad axes, axes, on-ellipse, extremes
		send_item(32'h0001_0000, 32'h0000_0000, 32'h1, 32'h1);
		send_item(32'h0001_0000, 32'h0002_0000, 32'h1, 32'h1);
		send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(32'hFFFF_FFFF, 32'h0000_0001, 32'h0, 32'h0);
		send_item(32'h0002_0000, 32'h0001_0000, 32'h0, 32'h0003_0000);
		send_item(32'h0002_0000, 32'h0001_0000, 32'h0, 32'h0000_8000);
		send_item(32'h0002_0000, 32'h0001_0000, 32'h0003_0000, 32'h0);
		send_item(32'h0002_0000, 32'h0001_0000, 32'h0000_4000, 32'h0);
		send_item(32'h0002_0000, 32'h0002_0000, 32'h0000_4000, 32'h0);
		send_item(32'h0002_0000, 32'h0001_0000, 32'h0002_0000, 32'h0);
		send_item(32'h0002_0000, 32'h0001_0000, 32'h0, 32'h0001_0000);
		send_item(32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
		send_item(32'h0002_0000, 32'h0001_0000, 32'h0000_8000, 32'h0000_4000);
		send_item(32'h0005_0000, 32'h0003_0000, 32'h0003_0000, 32'h0002_6666);
		send_item(32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
		send_item(32'h0000_0003, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001);
		send_item(32'h0000_0003, 32'h0000_0002, 32'h0000_0001, 32'hFFFF_FFFF);
		send_item(32'hFFFF_FFFF, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA);
		send_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_0001);
		send_item(32'h0000_0000, 32'h0000_0000, 32'h0, 32'h0);
		// hold off until the block has drained
		drain_results();

		// random phases with varying sender idling
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 0) ? 0 : (ph == 1) ? 62 : (ph == 2) ? 23 : 0;
			for (int i = 0; i < 210; i++)
				send_random();
		end

		drain_results();
		repeat (20) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule

FILE: point_ellipse_distance.f
+incdir+rtl/core
rtl/core/ped_pkg.sv
rtl/core/ped_alu.sv
rtl/core/point_ellipse_distance.sv
tb/tb_point_ellipse_distance.sv
